[src/qpdt_pkg.sv]
// Package for the quaternion PD orientation torque core: widths, register indexes,
// CORDIC arctangent table and shared helper functions. No dependencies.
`default_nettype none
package qpdt_pkg;
    localparam int QW = 16;
    localparam int TW = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int ROOT_BITS = 15;
    localparam int DIV_BITS = 30;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_TARGET_W = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_X = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_Y = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_Z = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPRING   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DAMPING  = 3'd5;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [19:0] PI_Q16 = 20'sd205887;
    localparam logic [14:0] ANGLE_STOP = 15'd41;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_vec16;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               stop;
    } t_result;

    function automatic logic signed [19:0] atan_q16(input int i);
        unique case (i)
            0: return 20'sd51472;
            1: return 20'sd30386;
            2: return 20'sd16055;
            3: return 20'sd8150;
            4: return 20'sd4091;
            5: return 20'sd2047;
            6: return 20'sd1024;
            7: return 20'sd512;
            8: return 20'sd256;
            9: return 20'sd128;
            10: return 20'sd64;
            11: return 20'sd32;
            12: return 20'sd16;
            13: return 20'sd8;
            14: return 20'sd4;
            default: return 20'sd2;
        endcase
    endfunction

    function automatic logic signed [15:0] round_q14(input logic signed [33:0] acc);
        logic signed [33:0] t;
        t = (acc + 34'sd8192) >>> 14;
        if (t > 34'sd32767) return 16'sh7fff;
        if (t < -34'sd32768) return 16'sh8000;
        return t[15:0];
    endfunction
endpackage
`default_nettype wire

[src/qpdt_if.sv]
// Valid/ready channel interfaces for the quaternion PD orientation torque core.
// No dependencies.
`default_nettype none
interface qpdt_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] cur_w;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] cur_z;
    logic signed [15:0] omega_x;
    logic signed [15:0] omega_y;
    logic signed [15:0] omega_z;
    modport source (output valid, cur_w, cur_x, cur_y, cur_z, omega_x, omega_y, omega_z,
                    input ready);
    modport sink (input valid, cur_w, cur_x, cur_y, cur_z, omega_x, omega_y, omega_z,
                  output ready);
endinterface

interface qpdt_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic stop_spin;
    modport source (output valid, torque_x, torque_y, torque_z, stop_spin, input ready);
    modport sink (input valid, torque_x, torque_y, torque_z, stop_spin, output ready);
endinterface

interface qpdt_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/qpdt_div.sv]
// Pipelined restoring divider: one quotient bit per stage, stalls with enable.
// Depends on qpdt_pkg. Divides a 30-bit magnitude by a 15-bit root.
`default_nettype none
module qpdt_div #(
    parameter int NB = qpdt_pkg::DIV_BITS,
    parameter int DB = qpdt_pkg::ROOT_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NB-1:0] i_num,
    input  wire logic [DB-1:0] i_den,
    output logic      [NB-1:0] o_quo
);
    logic [NB-1:0] r_num [NB+1];
    logic [DB:0]   r_rem [NB+1];
    logic [DB-1:0] r_den [NB+1];

    always_comb begin
        r_num[0] = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
    end

    for (genvar k = 0; k < NB; k++) begin : g_st
        logic [DB+1:0] n_sh;
        logic [DB+1:0] n_df;
        assign n_sh = {r_rem[k], r_num[k][NB-1-k]};
        assign n_df = n_sh - {2'b00, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k+1] <= r_den[k];
                if (!n_df[DB+1]) begin
                    r_rem[k+1] <= n_df[DB:0];
                    r_num[k+1] <= r_num[k] | (NB'(1) << (NB-1-k));
                end else begin
                    r_rem[k+1] <= n_sh[DB:0];
                    r_num[k+1] <= r_num[k] & ~(NB'(1) << (NB-1-k));
                end
            end
        end
    end

    assign o_quo = r_num[NB];
endmodule
`default_nettype wire

[src/quaternion_pd_orientation_torque_core.sv]
// Top level of the quaternion PD orientation torque core.
// Depends on qpdt_pkg, qpdt_if and qpdt_div.
// Throughput one transaction per cycle while the output is not stalled.
// The whole datapath advances together on a single enable; a stall holds every stage.
// Depth is set by the bit-serial square root (15 stages), CORDIC (16) and divider (30).
// Synchronous active-low reset clears valid bits and loads register reset values.
`default_nettype none
module quaternion_pd_orientation_torque_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qpdt_cfg_if.sink  i_cfg,
    qpdt_in_if.sink   i_in,
    qpdt_out_if.source o_out
);
    import qpdt_pkg::*;

    localparam int S_PROD = 2;
    localparam int S_ROOT = ROOT_BITS;
    localparam int S_CORD = CORDIC_STEPS;
    localparam int S_DIV  = DIV_BITS + 1;
    localparam int LAT = S_PROD + 1 + S_ROOT + S_CORD + S_DIV + 3;

    logic signed [15:0] r_tw, r_tx, r_ty, r_tz;
    logic [15:0] r_spring, r_damp;
    logic [LAT-1:0] r_vld;
    logic en;

    assign en = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw <= ONE_Q14; r_tx <= '0; r_ty <= '0; r_tz <= '0;
            r_spring <= '0; r_damp <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TARGET_W: r_tw <= i_cfg.data;
                REG_TARGET_X: r_tx <= i_cfg.data;
                REG_TARGET_Y: r_ty <= i_cfg.data;
                REG_TARGET_Z: r_tz <= i_cfg.data;
                REG_SPRING:   r_spring <= i_cfg.data;
                REG_DAMPING:  r_damp <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], i_in.valid};
    end

    // omega delay line
    t_vec16 r_om [LAT-2];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_om[0] <= '{i_in.omega_x, i_in.omega_y, i_in.omega_z};
            for (int k = 1; k < LAT-2; k++) r_om[k] <= r_om[k-1];
        end
    end

    // stage 1: products
    logic signed [31:0] r_p [16];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0]  <= i_in.cur_w * r_tw; r_p[1]  <= i_in.cur_x * r_tx;
            r_p[2]  <= i_in.cur_y * r_ty; r_p[3]  <= i_in.cur_z * r_tz;
            r_p[4]  <= i_in.cur_w * r_tx; r_p[5]  <= r_tw * i_in.cur_x;
            r_p[6]  <= i_in.cur_y * r_tz; r_p[7]  <= i_in.cur_z * r_ty;
            r_p[8]  <= i_in.cur_w * r_ty; r_p[9]  <= r_tw * i_in.cur_y;
            r_p[10] <= i_in.cur_z * r_tx; r_p[11] <= i_in.cur_x * r_tz;
            r_p[12] <= i_in.cur_w * r_tz; r_p[13] <= r_tw * i_in.cur_z;
            r_p[14] <= i_in.cur_x * r_ty; r_p[15] <= i_in.cur_y * r_tx;
        end
    end

    // stage 2: sums, rounding, clamp of w
    t_quat r_d;
    always_ff @(posedge i_clk) begin
        logic signed [15:0] w;
        if (en) begin
            w = round_q14(34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]) + 34'(r_p[3]));
            if (w > ONE_Q14) w = ONE_Q14;
            if (w < -ONE_Q14) w = -ONE_Q14;
            r_d.w <= w;
            r_d.x <= round_q14(34'(r_p[4]) - 34'(r_p[5]) - 34'(r_p[6]) + 34'(r_p[7]));
            r_d.y <= round_q14(34'(r_p[8]) - 34'(r_p[9]) - 34'(r_p[10]) + 34'(r_p[11]));
            r_d.z <= round_q14(34'(r_p[12]) - 34'(r_p[13]) - 34'(r_p[14]) + 34'(r_p[15]));
        end
    end

    // stage 3: radicand
    logic [28:0] r_rad;
    t_quat r_d3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= 29'(30'sd268435456 - 30'(r_d.w * r_d.w));
            r_d3 <= r_d;
        end
    end

    // bit-serial square root, one result bit per stage
    logic [28:0] r_sq_n [S_ROOT+1];
    logic [14:0] r_sq_r [S_ROOT+1];
    t_quat       r_sq_d [S_ROOT+1];
    always_comb begin
        r_sq_n[0] = r_rad;
        r_sq_r[0] = '0;
        r_sq_d[0] = r_d3;
    end
    for (genvar k = 0; k < S_ROOT; k++) begin : g_sq
        logic [14:0] trial;
        logic [29:0] sqv;
        assign trial = r_sq_r[k] | (15'(1) << (S_ROOT-1-k));
        assign sqv = 30'(trial) * 30'(trial);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_n[k+1] <= r_sq_n[k];
                r_sq_d[k+1] <= r_sq_d[k];
                r_sq_r[k+1] <= (sqv <= 30'(r_sq_n[k])) ? trial : r_sq_r[k];
            end
        end
    end

    // CORDIC vectoring for acos
    logic signed [20:0] r_cx [S_CORD+1];
    logic signed [20:0] r_cy [S_CORD+1];
    logic signed [21:0] r_cz [S_CORD+1];
    t_quat              r_cd [S_CORD+1];
    logic [14:0]        r_cs [S_CORD+1];
    always_comb begin
        r_cs[0] = r_sq_r[S_ROOT];
        r_cd[0] = r_sq_d[S_ROOT];
        if (r_cd[0].w >= 0) begin
            r_cx[0] = 21'(r_cd[0].w);
            r_cy[0] = 21'($signed({1'b0, r_cs[0]}));
            r_cz[0] = '0;
        end else begin
            r_cx[0] = 21'($signed({1'b0, r_cs[0]}));
            r_cy[0] = -21'(r_cd[0].w);
            r_cz[0] = 22'(HALF_PI_Q16);
        end
    end
    for (genvar k = 0; k < S_CORD; k++) begin : g_cd
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cd[k+1] <= r_cd[k];
                r_cs[k+1] <= r_cs[k];
                if (r_cy[k] > 0) begin
                    r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                    r_cz[k+1] <= r_cz[k] + 22'(atan_q16(k));
                end else begin
                    r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                    r_cz[k+1] <= r_cz[k] - 22'(atan_q16(k));
                end
            end
        end
    end

    // clamp and round the angle
    logic [14:0] ang_c;
    always_comb begin
        logic signed [21:0] z;
        logic [22:0] t;
        z = r_cz[S_CORD];
        if (z < 0) z = '0;
        if (z > 22'(PI_Q16)) z = 22'(PI_Q16);
        t = (23'(z) << 1) + 23'd8;
        ang_c = t[18:4];
    end

    // axis divisions with angle carried alongside
    logic [29:0] num_x, num_y, num_z, q_x, q_y, q_z;
    logic [14:0] den;
    t_quat dq;
    assign dq = r_cd[S_CORD];
    assign den = r_cs[S_CORD];
    assign num_x = {dq.x[15] ? 16'(-dq.x) : 16'(dq.x), 14'd0};
    assign num_y = {dq.y[15] ? 16'(-dq.y) : 16'(dq.y), 14'd0};
    assign num_z = {dq.z[15] ? 16'(-dq.z) : 16'(dq.z), 14'd0};

    qpdt_div u_div_x (.i_clk, .i_en(en), .i_num(num_x), .i_den(den), .o_quo(q_x));
    qpdt_div u_div_y (.i_clk, .i_en(en), .i_num(num_y), .i_den(den), .o_quo(q_y));
    qpdt_div u_div_z (.i_clk, .i_en(en), .i_num(num_z), .i_den(den), .o_quo(q_z));

    logic [14:0] r_ang [DIV_BITS];
    logic [3:0]  r_sgn [DIV_BITS];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang[0] <= ang_c;
            r_sgn[0] <= {den < 15'd2, dq.x[15], dq.y[15], dq.z[15]};
            for (int k = 1; k < DIV_BITS; k++) begin
                r_ang[k] <= r_ang[k-1];
                r_sgn[k] <= r_sgn[k-1];
            end
        end
    end

    // axis assembly
    logic signed [30:0] r_ax, r_ay, r_az;
    logic [14:0] r_ang2;
    always_ff @(posedge i_clk) begin
        logic [3:0] sg;
        if (en) begin
            sg = r_sgn[DIV_BITS-1];
            r_ang2 <= r_ang[DIV_BITS-1];
            if (sg[3]) begin
                r_ax <= 31'sd16384; r_ay <= '0; r_az <= '0;
            end else begin
                r_ax <= sg[2] ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
                r_ay <= sg[1] ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
                r_az <= sg[0] ? -$signed({1'b0, q_z}) : $signed({1'b0, q_z});
            end
        end
    end

    // axis times angle (31 x 16)
    logic signed [45:0] r_aa_x, r_aa_y, r_aa_z;
    logic [14:0] r_ang3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_aa_x <= r_ax * $signed({1'b0, r_ang2});
            r_aa_y <= r_ay * $signed({1'b0, r_ang2});
            r_aa_z <= r_az * $signed({1'b0, r_ang2});
            r_ang3 <= r_ang2;
        end
    end

    // spring term as two 23-bit partial products, damping term
    logic signed [70:0] r_sp_x, r_sp_y, r_sp_z;
    logic signed [33:0] r_dm_x, r_dm_y, r_dm_z;
    logic r_stop;
    t_vec16 om;
    assign om = r_om[LAT-3];
    function automatic logic signed [70:0] mul_gain(input logic signed [45:0] a,
                                                    input logic [15:0] g);
        logic signed [70:0] lo, hi;
        lo = 71'($signed({1'b0, a[22:0]})) * 71'($signed({1'b0, g}));
        hi = 71'($signed(a[45:23])) * 71'($signed({1'b0, g}));
        return (hi <<< 23) + lo;
    endfunction
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sp_x <= mul_gain(r_aa_x, r_spring);
            r_sp_y <= mul_gain(r_aa_y, r_spring);
            r_sp_z <= mul_gain(r_aa_z, r_spring);
            r_dm_x <= om.x * $signed({1'b0, r_damp});
            r_dm_y <= om.y * $signed({1'b0, r_damp});
            r_dm_z <= om.z * $signed({1'b0, r_damp});
            r_stop <= r_ang3 < ANGLE_STOP;
        end
    end

    function automatic logic signed [31:0] sat_out(input logic signed [70:0] sp,
                                                   input logic signed [33:0] dm);
        logic signed [70:0] t;
        t = ((sp + (71'sd1 <<< 25)) >>> 26) - 71'(dm);
        if (t > 71'sh7fffffff) return 32'sh7fffffff;
        if (t < -71'sh80000000) return 32'sh80000000;
        return t[31:0];
    endfunction

    t_result r_res;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= '{sat_out(r_sp_x, r_dm_x), sat_out(r_sp_y, r_dm_y),
                       sat_out(r_sp_z, r_dm_z), r_stop};
        end
    end

    assign o_out.valid = r_vld[LAT-1];
    assign o_out.torque_x = r_res.x;
    assign o_out.torque_y = r_res.y;
    assign o_out.torque_z = r_res.z;
    assign o_out.stop_spin = r_res.stop;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(r_res) && o_out.valid)
        else $error("result changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted transaction lost");
endmodule
`default_nettype wire
